### rtl/version_string_parser_macros.svh
// ---------------------------------------------------------------------------
// Version string parser assertion macros
// Concurrent assertion wrappers clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef VERSION_STRING_PARSER_MACROS_SVH
`define VERSION_STRING_PARSER_MACROS_SVH

// Same-cycle implication.
`define VSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("version_string_parser check failed");

// Next-cycle implication.
`define VSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("version_string_parser check failed");

`endif

### rtl/vsp_pkg.sv
// ---------------------------------------------------------------------------
// vsp_pkg
// Shared types, widths and codes of the version string parser.
// ---------------------------------------------------------------------------
package vsp_pkg;

  localparam int MaxLenDefault = 255;
  localparam int NumW          = 31;
  localparam int StatusW       = 3;
  localparam int LenW          = 8;
  localparam int ByteW         = 8;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_NS   = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_SRV  = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_MAJ  = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_MIN  = 3'd4;
  localparam logic [StatusW-1:0] ST_TOO_LONG = 3'd5;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    namespace_length;
    logic [NumW-1:0]    server_number;
    logic [NumW-1:0]    major_number;
    logic [NumW-1:0]    minor_number;
  } result_t;

endpackage

### rtl/vsp_if.sv
// ---------------------------------------------------------------------------
// vsp channel interfaces
// Valid/ready channels for input bytes and parse results.
// ---------------------------------------------------------------------------
interface vsp_char_if;
  import vsp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] char_byte;
  logic             last_byte;
  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface vsp_result_if;
  import vsp_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [LenW-1:0]    namespace_length;
  logic [NumW-1:0]    server_number;
  logic [NumW-1:0]    major_number;
  logic [NumW-1:0]    minor_number;
  modport source (output valid, output status, output namespace_length,
                  output server_number, output major_number, output minor_number,
                  input ready);
  modport sink   (input valid, input status, input namespace_length,
                  input server_number, input major_number, input minor_number,
                  output ready);
endinterface

### rtl/vsp_parse.sv
// ---------------------------------------------------------------------------
// vsp_parse
// Parse state registers and the one-byte update; forms the result on the
// last byte and returns to the start state.
// ---------------------------------------------------------------------------
module vsp_parse #(
  parameter int MAX_LEN = vsp_pkg::MaxLenDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [vsp_pkg::ByteW-1:0] char_byte,
  input  logic                     last_byte,
  output logic                     res_valid,
  output vsp_pkg::result_t         res
);
  import vsp_pkg::*;

  localparam int BcW = $clog2(MAX_LEN + 2);

  localparam logic [1:0] PH_NS     = 2'd0;
  localparam logic [1:0] PH_SERVER = 2'd1;
  localparam logic [1:0] PH_MAJOR  = 2'd2;
  localparam logic [1:0] PH_MINOR  = 2'd3;

  localparam logic [1:0] NS_WS     = 2'd0;
  localparam logic [1:0] NS_SIGN   = 2'd1;
  localparam logic [1:0] NS_DIGITS = 2'd2;

  logic [1:0]         phase, phase_next;
  logic [1:0]         number_step, number_step_next;
  logic               minus_seen, minus_seen_next;
  logic [NumW-1:0]    accumulator, accumulator_next;
  logic               overflow_seen, overflow_seen_next;
  logic [LenW-1:0]    letter_count, letter_count_next;
  logic [BcW-1:0]     byte_count, byte_count_next;
  logic [NumW-1:0]    server_hold, server_hold_next;
  logic [NumW-1:0]    major_hold, major_hold_next;
  logic [StatusW-1:0] error_code, error_code_next;

  logic               is_digit, is_ws, is_sign;
  logic [NumW+3:0]    prod;
  logic [StatusW-1:0] field_err;
  logic [StatusW-1:0] status;

  function automatic logic num_good(logic [1:0] st, logic ovf, logic neg,
                                    logic [NumW-1:0] acc);
    return (st == NS_DIGITS) && !ovf && !(neg && (acc != '0));
  endfunction

  assign is_digit  = (char_byte >= 8'd48) && (char_byte <= 8'd57);
  assign is_ws     = (char_byte == 8'd32) || ((char_byte >= 8'd9) && (char_byte <= 8'd13));
  assign is_sign   = (char_byte == 8'd43) || (char_byte == 8'd45);
  // acc * 10 + digit as two shifts and two adds
  assign prod      = ({4'b0, accumulator} << 3) + ({4'b0, accumulator} << 1)
                   + {{(NumW){1'b0}}, char_byte[3:0]};
  assign field_err = {1'b0, phase} + 3'd1;

  always_comb begin
    phase_next         = phase;
    number_step_next   = number_step;
    minus_seen_next    = minus_seen;
    accumulator_next   = accumulator;
    overflow_seen_next = overflow_seen;
    letter_count_next  = letter_count;
    server_hold_next   = server_hold;
    major_hold_next    = major_hold;
    error_code_next    = error_code;
    byte_count_next    = byte_count;

    if (byte_count <= BcW'(MAX_LEN)) begin
      byte_count_next = byte_count + 1'b1;
    end

    if (error_code == ST_OK) begin
      if (phase == PH_NS) begin
        if ((char_byte >= 8'd97) && (char_byte <= 8'd122)) begin
          if (letter_count != '1) begin
            letter_count_next = letter_count + 1'b1;
          end
        end else if ((char_byte == 8'd58) && (letter_count != '0)) begin
          phase_next         = PH_SERVER;
          number_step_next   = NS_WS;
          minus_seen_next    = 1'b0;
          accumulator_next   = '0;
          overflow_seen_next = 1'b0;
        end else begin
          error_code_next = ST_BAD_NS;
        end
      end else if ((char_byte == 8'd46) && (phase != PH_MINOR)) begin
        if (!num_good(number_step, overflow_seen, minus_seen, accumulator)) begin
          error_code_next = field_err;
        end else begin
          if (phase == PH_SERVER) begin
            server_hold_next = accumulator;
          end else begin
            major_hold_next = accumulator;
          end
          phase_next         = phase + 2'd1;
          number_step_next   = NS_WS;
          minus_seen_next    = 1'b0;
          accumulator_next   = '0;
          overflow_seen_next = 1'b0;
        end
      end else if (is_digit) begin
        if (|prod[NumW+3:NumW]) begin
          overflow_seen_next = 1'b1;
        end else begin
          accumulator_next = prod[NumW-1:0];
        end
        number_step_next = NS_DIGITS;
      end else if ((number_step == NS_WS) && is_ws) begin
        number_step_next = NS_WS;
      end else if ((number_step == NS_WS) && is_sign) begin
        minus_seen_next  = (char_byte == 8'd45);
        number_step_next = NS_SIGN;
      end else begin
        error_code_next = field_err;
      end
    end

    if (byte_count_next > BcW'(MAX_LEN)) begin
      status = ST_TOO_LONG;
    end else if (error_code_next != ST_OK) begin
      status = error_code_next;
    end else if (phase_next != PH_MINOR) begin
      status = {1'b0, phase_next} + 3'd1;
    end else if (num_good(number_step_next, overflow_seen_next, minus_seen_next,
                          accumulator_next)) begin
      status = ST_OK;
    end else begin
      status = ST_BAD_MIN;
    end
  end

  assign res_valid = step && last_byte;

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.namespace_length = letter_count_next;
      res.server_number    = server_hold_next;
      res.major_number     = major_hold_next;
      res.minor_number     = accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase         <= PH_NS;
      number_step   <= NS_WS;
      minus_seen    <= 1'b0;
      accumulator   <= '0;
      overflow_seen <= 1'b0;
      letter_count  <= '0;
      byte_count    <= '0;
      server_hold   <= '0;
      major_hold    <= '0;
      error_code    <= ST_OK;
    end else if (step) begin
      phase         <= phase_next;
      number_step   <= number_step_next;
      minus_seen    <= minus_seen_next;
      accumulator   <= accumulator_next;
      overflow_seen <= overflow_seen_next;
      letter_count  <= letter_count_next;
      byte_count    <= byte_count_next;
      server_hold   <= server_hold_next;
      major_hold    <= major_hold_next;
      error_code    <= error_code_next;
    end
  end

endmodule

### rtl/vsp_out_reg.sv
// ---------------------------------------------------------------------------
// vsp_out_reg
// Result register driving the result channel.
// ---------------------------------------------------------------------------
module vsp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  vsp_pkg::result_t data,
  output logic             free,
  vsp_result_if.source     result_ch
);
  import vsp_pkg::*;

  logic    valid;
  result_t hold;

  assign free = !valid || result_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

  assign result_ch.valid            = valid;
  assign result_ch.status           = hold.status;
  assign result_ch.namespace_length = hold.namespace_length;
  assign result_ch.server_number    = hold.server_number;
  assign result_ch.major_number     = hold.major_number;
  assign result_ch.minor_number     = hold.minor_number;

endmodule

### rtl/version_string_parser.sv
// ---------------------------------------------------------------------------
// version_string_parser
// Streaming parser for namespace:server.major.minor strings.
// ---------------------------------------------------------------------------
// Takes one byte per cycle, with no gaps between strings, save for the stall
// below. A byte is registered on transfer and folded into the parse state as
// it leaves the input register; a string's result is loaded into the result
// register as its last byte leaves. A last byte waits in the input register
// while an earlier result is still held in the result register, and the bytes
// behind it wait with it; no other byte stalls. Status 5 (too long) wins over
// every other code; on any failure the length and numbers read as zero.
module version_string_parser #(
  parameter int MAX_LEN = vsp_pkg::MaxLenDefault
) (
  input  logic         clk,
  input  logic         rst,
  vsp_char_if.sink     char_ch,
  vsp_result_if.source result_ch
);
  import vsp_pkg::*;

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_last;
  logic             out_free;
  logic             advance;
  logic             res_valid;
  result_t          res;

  assign advance       = s1_valid && (!s1_last || out_free);
  assign char_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ch.valid && char_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ch.valid && char_ch.ready) begin
      s1_byte <= char_ch.char_byte;
      s1_last <= char_ch.last_byte;
    end
  end

  vsp_parse #(.MAX_LEN(MAX_LEN)) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_byte (s1_byte),
    .last_byte (s1_last),
    .res_valid (res_valid),
    .res       (res)
  );

  vsp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .data      (res),
    .free      (out_free),
    .result_ch (result_ch)
  );

endmodule

### rtl/vsp_checker.sv
// ---------------------------------------------------------------------------
// vsp_checker
// Port-level checks on the parser result channel.
// ---------------------------------------------------------------------------
`include "version_string_parser_macros.svh"

module vsp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [vsp_pkg::StatusW-1:0] status,
  input logic [vsp_pkg::LenW-1:0]    namespace_length,
  input logic [vsp_pkg::NumW-1:0]    server_number,
  input logic [vsp_pkg::NumW-1:0]    major_number,
  input logic [vsp_pkg::NumW-1:0]    minor_number
);
  import vsp_pkg::*;

  logic                                 fields_zero;
  logic [StatusW+LenW+3*NumW-1:0] payload;

  assign fields_zero = (namespace_length == '0) && (server_number == '0) &&
                       (major_number == '0) && (minor_number == '0);
  assign payload     = {status, namespace_length, server_number, major_number,
                        minor_number};

  `VSP_ASSERT_NOW(a_status_range, out_valid, status <= ST_TOO_LONG)
  `VSP_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK), fields_zero)
  `VSP_ASSERT_NOW(a_ok_has_ns, out_valid && (status == ST_OK), namespace_length != '0)
  `VSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(payload))

endmodule

bind version_string_parser vsp_checker u_vsp_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result_ch.valid),
  .out_ready        (result_ch.ready),
  .status           (result_ch.status),
  .namespace_length (result_ch.namespace_length),
  .server_number    (result_ch.server_number),
  .major_number     (result_ch.major_number),
  .minor_number     (result_ch.minor_number)
);
